@@ src/sos_pkg.sv @@
// Shared types, constants and helpers for the spiral order scanner.
package sos_pkg;

    localparam int DATA_W   = 32;
    localparam int MAX_ROWS = 8;
    localparam int MAX_COLS = 8;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int IDX_W    = 3;
    localparam int SIZE_W   = 4;
    localparam int CNT_W    = ADDR_W + 1;
    localparam int PROD_W   = 2 * SIZE_W;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT,
        DIR_UP
    } t_dir;

    typedef enum logic {
        REG_NUM_ROWS = 1'b0,
        REG_NUM_COLS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic load_we;
        logic start;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic load_done;
        logic walk_last;
        logic out_free;
    } t_sts;

    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [SIZE_W-1:0] v,
        input logic [SIZE_W-1:0] maxv
    );
        logic [SIZE_W-1:0] res;
        if (v == '0) begin
            res = SIZE_W'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

@@ src/sos_ctrl.sv @@
// Load/emit controller for the spiral order scanner.
module sos_ctrl
    import sos_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (i_in_valid && i_sts.load_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free && i_sts.walk_last) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.load_we = 1'b0;
        o_cmd.start   = 1'b0;
        o_cmd.step    = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_in_ready    = 1'b1;
                o_cmd.load_we = i_in_valid;
                o_cmd.start   = i_in_valid && i_sts.load_done;
            end
            ST_EMIT: begin
                o_cmd.step = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ src/sos_datapath.sv @@
// Element store, load counter, spiral walker and output register.
module sos_datapath
    import sos_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [SIZE_W-1:0]        i_rows,
    input  logic [SIZE_W-1:0]        i_cols,
    input  logic signed [DATA_W-1:0] i_element_value,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_out_value,
    output logic [IDX_W-1:0]         o_out_row,
    output logic [IDX_W-1:0]         o_out_col,
    output logic                     o_out_last
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    logic [ADDR_W-1:0] r_load_count;
    logic [CNT_W-1:0]  w_count_inc;
    logic [PROD_W-1:0] w_total_full;
    logic [CNT_W-1:0]  w_total;

    logic [IDX_W-1:0]  r_top, r_bottom, r_left, r_right, r_row, r_col;
    logic [IDX_W-1:0]  n_top, n_bottom, n_left, n_right, n_row, n_col;
    t_dir              r_dir, n_dir;
    logic [ADDR_W-1:0] r_remain;
    logic [PROD_W-1:0] w_addr_full;
    logic [ADDR_W-1:0] w_rd_addr;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    logic [IDX_W-1:0]  r_out_row, r_out_col;
    logic              r_out_last;

    assign w_count_inc  = {1'b0, r_load_count} + CNT_W'(1);
    assign w_total_full = {{SIZE_W{1'b0}}, i_rows} * {{SIZE_W{1'b0}}, i_cols};
    assign w_total      = w_total_full[CNT_W-1:0];
    assign w_addr_full  = {{(PROD_W-IDX_W){1'b0}}, r_row} * {{SIZE_W{1'b0}}, i_cols}
                        + {{(PROD_W-IDX_W){1'b0}}, r_col};
    assign w_rd_addr    = w_addr_full[ADDR_W-1:0];

    assign o_sts.load_done = (w_count_inc >= w_total);
    assign o_sts.walk_last = (r_remain == '0);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // element store: write on load, registered read on walk step
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            r_mem[r_load_count] <= i_element_value;
        end
        if (i_cmd.step) begin
            r_out_value <= r_mem[w_rd_addr];
            r_out_row   <= r_row;
            r_out_col   <= r_col;
            r_out_last  <= (r_remain == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count <= '0;
        end else if (i_cmd.load_we) begin
            r_load_count <= i_cmd.start ? '0 : w_count_inc[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // one spiral step per issued read
    always_comb begin
        n_top    = r_top;
        n_bottom = r_bottom;
        n_left   = r_left;
        n_right  = r_right;
        n_row    = r_row;
        n_col    = r_col;
        n_dir    = r_dir;
        case (r_dir)
            DIR_RIGHT: begin
                if (r_col < r_right) begin
                    n_col = r_col + IDX_W'(1);
                end else begin
                    n_dir = DIR_DOWN;
                    n_top = r_top + IDX_W'(1);
                    n_row = r_row + IDX_W'(1);
                end
            end
            DIR_DOWN: begin
                if (r_row < r_bottom) begin
                    n_row = r_row + IDX_W'(1);
                end else begin
                    n_dir   = DIR_LEFT;
                    n_right = r_right - IDX_W'(1);
                    n_col   = r_col - IDX_W'(1);
                end
            end
            DIR_LEFT: begin
                if (r_col > r_left) begin
                    n_col = r_col - IDX_W'(1);
                end else begin
                    n_dir    = DIR_UP;
                    n_bottom = r_bottom - IDX_W'(1);
                    n_row    = r_row - IDX_W'(1);
                end
            end
            DIR_UP: begin
                if (r_row > r_top) begin
                    n_row = r_row - IDX_W'(1);
                end else begin
                    n_dir  = DIR_RIGHT;
                    n_left = r_left + IDX_W'(1);
                    n_col  = r_col + IDX_W'(1);
                end
            end
            default: n_dir = DIR_RIGHT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir    <= DIR_RIGHT;
            r_remain <= '0;
            r_top    <= '0;
            r_bottom <= '0;
            r_left   <= '0;
            r_right  <= '0;
            r_row    <= '0;
            r_col    <= '0;
        end else if (i_cmd.start) begin
            r_dir    <= DIR_RIGHT;
            r_remain <= ADDR_W'(w_total - CNT_W'(1));
            r_top    <= '0;
            r_bottom <= IDX_W'(i_rows - SIZE_W'(1));
            r_left   <= '0;
            r_right  <= IDX_W'(i_cols - SIZE_W'(1));
            r_row    <= '0;
            r_col    <= '0;
        end else if (i_cmd.step) begin
            r_dir    <= n_dir;
            r_remain <= r_remain - ADDR_W'(1);
            r_top    <= n_top;
            r_bottom <= n_bottom;
            r_left   <= n_left;
            r_right  <= n_right;
            r_row    <= n_row;
            r_col    <= n_col;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_last  = r_out_last;

endmodule

@@ src/spiral_order_scanner.sv @@
// Spiral order scanner top level: size registers, controller and datapath.
// Loading takes one element per cycle; the request that completes the matrix
// starts the spiral: it initialises the walker, whose first step registers the first result.
// Results then follow at one per cycle while the sink is ready, paced by the
// element store's single registered read port: N loads plus N results per matrix.
// Synchronous active-low reset: sizes return to 1, load count and control clear,
// the element store is not cleared.
module spiral_order_scanner
    import sos_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [DATA_W-1:0] i_element_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_out_value,
    output logic [IDX_W-1:0]         o_out_row,
    output logic [IDX_W-1:0]         o_out_col,
    output logic                     o_out_last
);

    logic [SIZE_W-1:0] r_num_rows;
    logic [SIZE_W-1:0] r_num_cols;
    logic [SIZE_W-1:0] w_rows;
    logic [SIZE_W-1:0] w_cols;
    t_reg_idx          w_reg_idx;
    logic              w_wr_en;
    t_cmd              w_cmd;
    t_sts              w_sts;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[2]);
    assign w_wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= SIZE_W'(1);
            r_num_cols <= SIZE_W'(1);
        end else if (w_wr_en) begin
            case (w_reg_idx)
                REG_NUM_ROWS: r_num_rows <= pwdata[SIZE_W-1:0];
                REG_NUM_COLS: r_num_cols <= pwdata[SIZE_W-1:0];
                default: begin
                    r_num_rows <= r_num_rows;
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_NUM_ROWS: prdata = {{(APB_DW-SIZE_W){1'b0}}, r_num_rows};
            REG_NUM_COLS: prdata = {{(APB_DW-SIZE_W){1'b0}}, r_num_cols};
            default:      prdata = '0;
        endcase
    end

    assign w_rows = clamp_size(r_num_rows, SIZE_W'(MAX_ROWS));
    assign w_cols = clamp_size(r_num_cols, SIZE_W'(MAX_COLS));

    sos_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sos_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rows          (w_rows),
        .i_cols          (w_cols),
        .i_element_value (i_element_value),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_value     (o_out_value),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_out_last      (o_out_last)
    );

endmodule
